FILE: hw/rtl/ece_pkg.sv
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Shared field widths, default parameters, selector codes and segment control.
// ----------------------------------------------------------------------------
`default_nettype none

package ece_pkg;

  localparam int unsigned ACTION_W             = 3;
  localparam int unsigned LEVEL_W              = 16;
  localparam int unsigned EASED_W              = 17;
  localparam int unsigned FRACTION_BITS_DEF    = 15;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;

  // round(pi/2 * 2^30)
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE            = 3'd0,
    ACT_IN              = 3'd1,
    ACT_OUT             = 3'd2,
    ACT_IN_ELASTIC      = 3'd3,
    ACT_OUT_ELASTIC     = 3'd4,
    ACT_UP_DOWN         = 3'd5,
    ACT_UP_DOWN_ELASTIC = 3'd6,
    ACT_PASS            = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    SHAPE_LIN  = 2'd0,
    SHAPE_CUBE = 2'd1,
    SHAPE_SINE = 2'd2
  } shape_e;

  // flip: shape input is one minus position; neg: subtract scaled shape;
  // base_one: result is offset by one
  typedef struct packed {
    shape_e shape;
    logic   flip;
    logic   neg;
    logic   base_one;
  } seg_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ece_seg_dec.sv
// ----------------------------------------------------------------------------
// Segment decoder
// Saturates the level to one and picks the segment start, reciprocal length,
// magnitude and shape control for the selected curve.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_seg_dec #(
  parameter int unsigned FRACTION_BITS = ece_pkg::FRACTION_BITS_DEF
) (
  input  wire logic [ece_pkg::ACTION_W-1:0] action_i,
  input  wire logic [ece_pkg::LEVEL_W-1:0]  level_i,
  output logic [FRACTION_BITS:0]            level_o,
  output logic [FRACTION_BITS:0]            start_o,
  output logic [FRACTION_BITS+3:0]          recip_o,
  output logic [FRACTION_BITS:0]            mag_o,
  output ece_pkg::seg_ctl_t                 ctl_o
);

  localparam int unsigned NW   = FRACTION_BITS + 1;
  localparam int unsigned RW   = FRACTION_BITS + 4;
  localparam int unsigned CmpW = (NW > ece_pkg::LEVEL_W) ? NW : ece_pkg::LEVEL_W;

  localparam longint unsigned OneL    = 64'd1 << FRACTION_BITS;
  localparam longint unsigned Q1Of10  = (OneL + 64'd5) / 64'd10;
  localparam longint unsigned Q1Of4   = (OneL + 64'd2) / 64'd4;
  localparam longint unsigned Q3Of4   = (64'd3 * OneL + 64'd2) / 64'd4;
  localparam longint unsigned Q9Of10  = (64'd9 * OneL + 64'd5) / 64'd10;
  localparam longint unsigned Q1Of2   = (OneL + 64'd1) / 64'd2;
  localparam longint unsigned Q4Of5   = (64'd4 * OneL + 64'd2) / 64'd5;
  localparam longint unsigned Q1Of5   = (OneL + 64'd2) / 64'd5;
  localparam longint unsigned Q2Of5   = (64'd2 * OneL + 64'd2) / 64'd5;
  localparam longint unsigned Q3Of20  = (64'd3 * OneL + 64'd10) / 64'd20;
  localparam longint unsigned Q10     = 64'd10 * OneL;
  localparam longint unsigned Q20Of3  = (64'd20 * OneL + 64'd1) / 64'd3;
  localparam longint unsigned Q4Of3   = (64'd4 * OneL + 64'd1) / 64'd3;
  localparam longint unsigned Q2      = 64'd2 * OneL;
  localparam longint unsigned Q10Of3  = (64'd10 * OneL + 64'd1) / 64'd3;
  localparam longint unsigned Q5      = 64'd5 * OneL;

  logic [CmpW-1:0] lvl_ext;
  logic [NW-1:0]   n;

  assign lvl_ext = CmpW'(level_i);
  assign n       = (lvl_ext > CmpW'(OneL)) ? NW'(OneL) : NW'(lvl_ext);
  assign level_o = n;

  always_comb begin
    start_o = '0;
    recip_o = RW'(OneL);
    mag_o   = NW'(OneL);
    ctl_o   = '{shape: ece_pkg::SHAPE_LIN, flip: 1'b0, neg: 1'b0, base_one: 1'b0};
    unique case (ece_pkg::action_e'(action_i))
      ece_pkg::ACT_IN: begin
        ctl_o.shape = ece_pkg::SHAPE_CUBE;
      end
      ece_pkg::ACT_OUT: begin
        ctl_o = '{shape: ece_pkg::SHAPE_CUBE, flip: 1'b1, neg: 1'b1, base_one: 1'b1};
      end
      ece_pkg::ACT_IN_ELASTIC: begin
        priority if (n < NW'(Q1Of10)) begin
          recip_o   = RW'(Q10);
          mag_o     = NW'(Q1Of5);
          ctl_o     = '{shape: ece_pkg::SHAPE_SINE, flip: 1'b0, neg: 1'b1, base_one: 1'b0};
        end else if (n < NW'(Q1Of4)) begin
          start_o   = NW'(Q1Of10);
          recip_o   = RW'(Q20Of3);
          mag_o     = NW'(Q1Of10);
          ctl_o     = '{shape: ece_pkg::SHAPE_SINE, flip: 1'b0, neg: 1'b0, base_one: 1'b1};
        end else begin
          start_o   = NW'(Q1Of4);
          recip_o   = RW'(Q4Of3);
          ctl_o     = '{shape: ece_pkg::SHAPE_CUBE, flip: 1'b1, neg: 1'b1, base_one: 1'b1};
        end
      end
      ece_pkg::ACT_OUT_ELASTIC: begin
        priority if (n < NW'(Q3Of4)) begin
          recip_o   = RW'(Q4Of3);
          ctl_o.shape = ece_pkg::SHAPE_CUBE;
        end else if (n < NW'(Q9Of10)) begin
          start_o   = NW'(Q3Of4);
          recip_o   = RW'(Q20Of3);
          mag_o     = NW'(Q1Of5);
          ctl_o     = '{shape: ece_pkg::SHAPE_SINE, flip: 1'b0, neg: 1'b0, base_one: 1'b1};
        end else begin
          start_o   = NW'(Q9Of10);
          recip_o   = RW'(Q10);
          mag_o     = NW'(Q1Of10);
          ctl_o     = '{shape: ece_pkg::SHAPE_SINE, flip: 1'b0, neg: 1'b1, base_one: 1'b1};
        end
      end
      ece_pkg::ACT_UP_DOWN: begin
        ctl_o.shape = ece_pkg::SHAPE_SINE;
      end
      ece_pkg::ACT_UP_DOWN_ELASTIC: begin
        priority if (n < NW'(Q1Of2)) begin
          recip_o   = RW'(Q2);
          ctl_o.shape = ece_pkg::SHAPE_SINE;
        end else if (n < NW'(Q4Of5)) begin
          start_o   = NW'(Q1Of2);
          recip_o   = RW'(Q10Of3);
          mag_o     = NW'(Q2Of5);
          ctl_o     = '{shape: ece_pkg::SHAPE_SINE, flip: 1'b0, neg: 1'b1, base_one: 1'b0};
        end else begin
          start_o   = NW'(Q4Of5);
          recip_o   = RW'(Q5);
          mag_o     = NW'(Q3Of20);
          ctl_o.shape = ece_pkg::SHAPE_SINE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ece_sine_tab.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant table of sin(k/DEPTH * pi/2), built at elaboration from a Taylor
// series; returns the entry at an index and its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_sine_tab #(
  parameter int unsigned FRACTION_BITS    = ece_pkg::FRACTION_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = ece_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  wire logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] idx_i,
  output logic [FRACTION_BITS:0]                     lo_o,
  output logic [FRACTION_BITS:0]                     hi_o
);

  localparam int unsigned NW = FRACTION_BITS + 1;
  localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam longint unsigned Depth = 64'(SINE_TABLE_DEPTH);

  function automatic longint unsigned sine_entry(input longint unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x    = (k * ece_pkg::HALF_PI_Q30 + Depth / 64'd2) / Depth;
    term = x;
    sum  = longint'(x);
    for (int i = 1; i <= 7; i++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      unique case (i)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((i % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    return ((longint'(unsigned'(sum)) << FRACTION_BITS) + (64'd1 << 29)) >> 30;
  endfunction

  logic [NW-1:0] tab [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam longint unsigned Entry = sine_entry(64'(k));
    assign tab[k] = NW'(Entry);
  end

  logic          top;
  logic [IW-1:0] lo_idx;
  logic [IW-1:0] hi_idx;

  assign top    = (idx_i >= IW'(SINE_TABLE_DEPTH));
  assign lo_idx = top ? IW'(SINE_TABLE_DEPTH) : idx_i;
  assign hi_idx = top ? IW'(SINE_TABLE_DEPTH) : idx_i + IW'(1);
  assign lo_o   = tab[lo_idx];
  assign hi_o   = tab[hi_idx];

endmodule

`default_nettype wire

FILE: hw/rtl/easing_curve_evaluator.sv
// Easing curve evaluator. Takes a progress level (unsigned, one = 2^FRACTION_BITS,
// saturated to one) and a curve selector, and returns the eased value as a
// signed 17-bit word on the same scale. The datapath is an eight-stage
// pipeline: decode, segment position multiply, round and fold, square and
// table address, cube multiply and table read, interpolation multiply,
// magnitude multiply, and the output register. A transfer is accepted every
// cycle unless the input is stalled, and each item moves through the stage
// registers in order to the output. The segment position multiplier is
// (FRACTION_BITS+1) x (FRACTION_BITS+4) bits. Bubbles collapse, so input stall
// rises only when all eight stages hold items and the output is stalled.
// ----------------------------------------------------------------------------
// Easing curve evaluator top level
// Pipeline control and datapath registers around the segment decoder and the
// sine table.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_evaluator #(
  parameter int unsigned FRACTION_BITS    = ece_pkg::FRACTION_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = ece_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ece_pkg::ACTION_W-1:0]  action_i,
  input  wire logic [ece_pkg::LEVEL_W-1:0]   level_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [ece_pkg::EASED_W-1:0] eased_o
);

  localparam int unsigned NS = 8;
  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned NW = FB + 1;
  localparam int unsigned RW = FB + 4;
  localparam int unsigned PW = NW + RW;
  localparam int unsigned AW = PW - FB;
  localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned SW = FB + IW;
  localparam int unsigned MW = 2 * NW;
  localparam int unsigned XW = NW + FB;
  localparam int unsigned VW = NW + 2;

  localparam longint unsigned OneL  = 64'd1 << FB;
  localparam longint unsigned HalfL = 64'd1 << (FB - 1);
  localparam logic [NW-1:0]   OneN  = NW'(OneL);
  localparam logic [FB-1:0]   HalfF = FB'(HalfL);

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_d;
  logic [NS:0]   rdy;
  logic [NS-1:0] vld_prev;

  assign vld_prev = {vld_q[NS-2:0], in_valid_i};

  always_comb begin
    rdy[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      vld_d[k] = rdy[k] ? vld_prev[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // --------------------------------------------------------------------------
  // stage 0: saturate and decode
  // --------------------------------------------------------------------------
  logic [NW-1:0]     a_n_d, a_start_d, a_mag_d;
  logic [RW-1:0]     a_recip_d;
  ece_pkg::seg_ctl_t a_ctl_d;

  ece_seg_dec #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seg_dec (
    .action_i (action_i),
    .level_i  (level_i),
    .level_o  (a_n_d),
    .start_o  (a_start_d),
    .recip_o  (a_recip_d),
    .mag_o    (a_mag_d),
    .ctl_o    (a_ctl_d)
  );

  logic [NW-1:0]     a_n_q, a_start_q, a_mag_q;
  logic [RW-1:0]     a_recip_q;
  ece_pkg::seg_ctl_t a_ctl_q;

  // --------------------------------------------------------------------------
  // stage 1: segment position product
  // --------------------------------------------------------------------------
  logic [NW-1:0]     b_d;
  logic [PW-1:0]     b_prod_d, b_prod_q;
  logic [NW-1:0]     b_mag_q;
  ece_pkg::seg_ctl_t b_ctl_q;

  assign b_d      = (a_n_q < a_start_q) ? '0 : a_n_q - a_start_q;
  assign b_prod_d = PW'(b_d) * PW'(a_recip_q);

  // --------------------------------------------------------------------------
  // stage 2: round, limit to one, flip and fold
  // --------------------------------------------------------------------------
  logic [PW-1:0]     c_sum;
  logic [AW-1:0]     c_pos;
  logic [NW-1:0]     c_aux;
  logic [NW-1:0]     c_ac_d, c_ac_q;
  logic [FB-1:0]     c_fold_d, c_fold_q;
  logic [NW-1:0]     c_mag_q;
  ece_pkg::seg_ctl_t c_ctl_q;
  logic [NW-1:0]     c_inv;

  assign c_sum    = b_prod_q + PW'(HalfL);
  assign c_pos    = c_sum[PW-1:FB];
  assign c_aux    = (c_pos > AW'(OneL)) ? OneN : c_pos[NW-1:0];
  assign c_inv    = OneN - c_aux;
  assign c_ac_d   = b_ctl_q.flip ? c_inv : c_aux;
  assign c_fold_d = (c_aux <= NW'(HalfL)) ? c_aux[FB-1:0] : c_inv[FB-1:0];

  // --------------------------------------------------------------------------
  // stage 3: square and table address
  // --------------------------------------------------------------------------
  logic [MW-1:0]     d_sq_d, d_sq_q;
  logic [SW-1:0]     d_s;
  logic [IW-1:0]     d_idx_q;
  logic [FB-1:0]     d_frac_q;
  logic [NW-1:0]     d_ac_q, d_mag_q;
  ece_pkg::seg_ctl_t d_ctl_q;

  assign d_sq_d = MW'(c_ac_q) * MW'(c_ac_q);
  assign d_s    = SW'(c_fold_q) * SW'(2 * SINE_TABLE_DEPTH);

  // --------------------------------------------------------------------------
  // stage 4: cube product and table read
  // --------------------------------------------------------------------------
  logic [MW-1:0]     e_sq_sum;
  logic [NW-1:0]     e_sqr;
  logic [MW-1:0]     e_cub_d, e_cub_q;
  logic [NW-1:0]     e_lo_d, e_hi_d;
  logic [NW-1:0]     e_lo_q, e_diff_q, e_ac_q, e_mag_q;
  logic              e_dn_q;
  logic [FB-1:0]     e_frac_q;
  ece_pkg::seg_ctl_t e_ctl_q;

  assign e_sq_sum = d_sq_q + MW'(HalfL);
  assign e_sqr    = e_sq_sum[FB +: NW];
  assign e_cub_d  = MW'(e_sqr) * MW'(d_ac_q);

  ece_sine_tab #(
    .FRACTION_BITS    (FRACTION_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_tab (
    .idx_i (d_idx_q),
    .lo_o  (e_lo_d),
    .hi_o  (e_hi_d)
  );

  // --------------------------------------------------------------------------
  // stage 5: cube rounding and interpolation product
  // --------------------------------------------------------------------------
  logic [MW-1:0]     f_cub_sum;
  logic [NW-1:0]     f_cube_d, f_cube_q;
  logic [XW-1:0]     f_ip_d, f_ip_q;
  logic [NW-1:0]     f_lo_q, f_ac_q, f_mag_q;
  logic              f_dn_q;
  ece_pkg::seg_ctl_t f_ctl_q;

  assign f_cub_sum = e_cub_q + MW'(HalfL);
  assign f_cube_d  = f_cub_sum[FB +: NW];
  assign f_ip_d    = XW'(e_diff_q) * XW'(e_frac_q);

  // --------------------------------------------------------------------------
  // stage 6: shape select and magnitude product
  // --------------------------------------------------------------------------
  logic [NW-1:0]     g_step;
  logic [NW-1:0]     g_hs;
  logic [NW-1:0]     g_f;
  logic [MW-1:0]     g_mp_d, g_mp_q;
  ece_pkg::seg_ctl_t g_ctl_q;

  assign g_step = f_ip_q[FB +: NW];
  assign g_hs   = f_dn_q ? f_lo_q - g_step : f_lo_q + g_step;

  always_comb begin
    unique case (f_ctl_q.shape)
      ece_pkg::SHAPE_CUBE: g_f = f_cube_q;
      ece_pkg::SHAPE_SINE: g_f = g_hs;
      default:             g_f = f_ac_q;
    endcase
  end

  assign g_mp_d = MW'(g_f) * MW'(f_mag_q);

  // --------------------------------------------------------------------------
  // stage 7: round, sign and offset
  // --------------------------------------------------------------------------
  logic [MW-1:0]                      h_mp_sum;
  logic [NW-1:0]                      h_m;
  logic signed [VW-1:0]               h_base;
  logic signed [VW-1:0]               h_term;
  logic signed [VW-1:0]               h_v;
  logic signed [ece_pkg::EASED_W-1:0] eased_d, eased_q;

  assign h_mp_sum = g_mp_q + MW'(HalfL);
  assign h_m      = h_mp_sum[FB +: NW];
  assign h_base   = g_ctl_q.base_one ? $signed(VW'(OneL)) : '0;
  assign h_term   = $signed(VW'(h_m));
  assign h_v      = g_ctl_q.neg ? h_base - h_term : h_base + h_term;
  assign eased_d  = ece_pkg::EASED_W'(h_v);

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      a_n_q     <= a_n_d;
      a_start_q <= a_start_d;
      a_recip_q <= a_recip_d;
      a_mag_q   <= a_mag_d;
      a_ctl_q   <= a_ctl_d;
    end
    if (rdy[1]) begin
      b_prod_q <= b_prod_d;
      b_mag_q  <= a_mag_q;
      b_ctl_q  <= a_ctl_q;
    end
    if (rdy[2]) begin
      c_ac_q   <= c_ac_d;
      c_fold_q <= c_fold_d;
      c_mag_q  <= b_mag_q;
      c_ctl_q  <= b_ctl_q;
    end
    if (rdy[3]) begin
      d_sq_q   <= d_sq_d;
      d_idx_q  <= d_s[SW-1:FB];
      d_frac_q <= d_s[FB-1:0];
      d_ac_q   <= c_ac_q;
      d_mag_q  <= c_mag_q;
      d_ctl_q  <= c_ctl_q;
    end
    if (rdy[4]) begin
      e_cub_q  <= e_cub_d;
      e_lo_q   <= e_lo_d;
      e_dn_q   <= (e_hi_d < e_lo_d);
      e_diff_q <= (e_hi_d < e_lo_d) ? e_lo_d - e_hi_d : e_hi_d - e_lo_d;
      e_frac_q <= d_frac_q;
      e_ac_q   <= d_ac_q;
      e_mag_q  <= d_mag_q;
      e_ctl_q  <= d_ctl_q;
    end
    if (rdy[5]) begin
      f_cube_q <= f_cube_d;
      f_ip_q   <= f_ip_d;
      f_lo_q   <= e_lo_q;
      f_dn_q   <= e_dn_q;
      f_ac_q   <= e_ac_q;
      f_mag_q  <= e_mag_q;
      f_ctl_q  <= e_ctl_q;
    end
    if (rdy[6]) begin
      g_mp_q  <= g_mp_d;
      g_ctl_q <= f_ctl_q;
    end
    if (rdy[7]) begin
      eased_q <= eased_d;
    end
  end

  assign eased_o = eased_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while a pipeline stage is empty");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted transfer did not enter the first stage");

  a_position_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> ((c_ac_q <= OneN) && (c_fold_q <= HalfF)))
    else $error("segment position out of range");

  a_output_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !vld_q[NS-2]) |=> !out_valid_o)
    else $error("output repeated after transfer");

endmodule

`default_nettype wire
